// ===== rtl/aes128_block_encrypt_assert.svh =====
// Assertion macros for the AES-128 encryption block.
`ifndef AES128_BLOCK_ENCRYPT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_ASSERT_SVH
// Implication checked every clock, quiet during reset.
`define AES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, also checked through reset.
`define AES_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/aes_pkg.sv =====
// Package: S-box table, GF helpers and round function for AES-128.
package aes_pkg;
   localparam int unsigned NumRounds = 10;
   localparam logic [0:0] CsrKeyHigh = 1'b0;
   localparam logic [0:0] CsrKeyLow  = 1'b1;

   typedef logic [127:0] block_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Byte i of a block; byte 0 sits in the top bits.
   function automatic logic [7:0] get_byte(input block_type b, input int unsigned i);
      get_byte = b[127 - 8 * i -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Next round key from the previous one.
   function automatic block_type next_key(input block_type k, input logic [7:0] rc);
      logic [31:0] w [4];
      logic [31:0] t;
      block_type r;
      for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
      t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
      w[0] = w[0] ^ t;
      for (int i = 1; i < 4; i++) w[i] = w[i] ^ w[i - 1];
      for (int i = 0; i < 4; i++) r[127 - 32 * i -: 32] = w[i];
      next_key = r;
   endfunction

   // SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
   function automatic block_type round_fn(input block_type s, input block_type k,
                                          input logic mix);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      block_type r;
      for (int c = 0; c < 4; c++)
         for (int q = 0; q < 4; q++)
            t[4 * c + q] = SBOX[get_byte(s, 4 * ((c + q) % 4) + q)];
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
            t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
      round_fn = r ^ k;
   endfunction
endpackage

// ===== rtl/aes_if.sv =====
// Interfaces: data stream channel and configuration write channel.
interface aes_stream_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_high;
   logic [63:0] data_low;
   modport source (output valid, output data_high, output data_low, input ready);
   modport sink (input valid, input data_high, input data_low, output ready);
endinterface

interface aes_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/aes_round_stage.sv =====
// One pipeline stage: an AES round on the state and the key-schedule step.
module aes_round_stage
   import aes_pkg::*;
#(
   parameter logic [7:0] RCON = 8'h01,
   parameter bit         MIX  = 1'b1
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_in,
   input  block_type state_in,
   input  block_type key_in,
   output logic      valid_out,
   output block_type state_out,
   output block_type key_out
);
   logic      valid_ff;
   block_type state_ff, key_ff, key_nx;

   assign key_nx = next_key(key_in, RCON);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= round_fn(state_in, key_nx, MIX);
         key_ff   <= key_nx;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out   = key_ff;
endmodule

// ===== rtl/aes128_block_encrypt.sv =====
// Top level: pipelined AES-128 block encryption, one block per cycle while rsp is not held.
// Usage:
//  - req: plaintext halves (byte 0 in the top of data_high). A transfer
//    happens when valid and ready are both high.
//  - rsp: ciphertext halves, same byte order, one result per request.
//  - csr: index 0 writes key_high, index 1 key_low; always ready. Write
//    only while no block is in flight. The key travels down the pipe with
//    each block, expanded one round per stage.
//  - Pipeline: eleven registers (one after the initial AddRoundKey, then one
//    stage per round) lie between the req transfer and rsp valid.
//  - Throughput: one block per cycle while rsp is not held; each stage
//    holds one round, set by the S-box plus MixColumns depth of a round.
//  - Stall: while rsp is held, the whole pipe freezes; req ready is low
//    only when the output stage is full and not taken. Nothing is lost.
//  - Reset: key registers clear to zero, all stage valid bits clear.
module aes128_block_encrypt
   import aes_pkg::*;
(
   input  logic clock,
   input  logic reset,
   aes_stream_if.sink   req,
   aes_stream_if.source rsp,
   aes_csr_if.sink      csr
);
`include "aes128_block_encrypt_assert.svh"

   logic [63:0] key_high_ff, key_low_ff;
   logic        advance;
   logic        valid_s [NumRounds + 1];
   block_type   state_s [NumRounds + 1];
   block_type   key_s   [NumRounds + 1];
   logic        v0_ff;
   block_type   st0_ff, k0_ff;

   // Pipe moves whenever the last stage is empty or being taken.
   assign advance = !valid_s[NumRounds] || rsp.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            CsrKeyHigh: key_high_ff <= csr.data;
            CsrKeyLow:  key_low_ff  <= csr.data;
            default:    ;
         endcase
      end
   end

   // Initial AddRoundKey stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         st0_ff <= {req.data_high, req.data_low} ^ {key_high_ff, key_low_ff};
         k0_ff  <= {key_high_ff, key_low_ff};
      end
   end
   assign valid_s[0] = v0_ff;
   assign state_s[0] = st0_ff;
   assign key_s[0]   = k0_ff;

   localparam logic [7:0] RCON [NumRounds] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                              8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      aes_round_stage #(
         .RCON (RCON[g]),
         .MIX  (g != NumRounds - 1)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (valid_s[g]),
         .state_in  (state_s[g]),
         .key_in    (key_s[g]),
         .valid_out (valid_s[g + 1]),
         .state_out (state_s[g + 1]),
         .key_out   (key_s[g + 1])
      );
   end

   assign rsp.valid     = valid_s[NumRounds];
   assign rsp.data_high = state_s[NumRounds][127:64];
   assign rsp.data_low  = state_s[NumRounds][63:0];

   // A held result freezes the output stage; reset clears the output valid.
   `AES_ASSERT_IMP(a_hold, clock, reset, rsp.valid && !rsp.ready,
      req.ready == 1'b0, "req ready while output stalled")
   `AES_ASSERT_NEXT(a_stall_keep, clock, !reset && rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.data_high), "stalled result changed")
   `AES_ASSERT_NEXT(a_reset_clear, clock, reset, !rsp.valid, "valid after reset")
endmodule

// ===== verif/aes128_block_encrypt_tb_if.sv =====
// Testbench-side note: the channel interfaces come from the RTL; this file holds the block half-pair record.
package aes128_block_encrypt_tb_pkg;
   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } aes_half_pair_type;
endpackage

// ===== verif/aes128_block_encrypt_tb.sv =====
// Self-checking testbench for the AES-128 block encryption pipeline.
module aes128_block_encrypt_tb;
   import aes_pkg::*;
   import aes128_block_encrypt_tb_pkg::*;

   localparam int PipeLatency   = 11;
   localparam int RandomBlocks  = 1350;
   localparam int WatchdogLimit = 2000;

   logic clock;
   logic reset;

   aes_stream_if req_if ();
   aes_stream_if rsp_if ();
   aes_csr_if    csr_if ();

   aes128_block_encrypt dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source),
      .csr   (csr_if.sink)
   );

   // Predictor key, mirrors the two key registers.
   logic [63:0] model_key_high;
   logic [63:0] model_key_low;

   aes_half_pair_type plain_q [$];     // blocks waiting for the driver
   aes_half_pair_type cipher_q [$];    // expected ciphertexts, oldest first
   int error_count;
   int idle_cycles;
   bit stim_done;
   bit hold_sender;                 // forces a drain pause in the driver

   // S-box built from its algebraic definition (inverse, then affine map).
   logic [7:0] sbox_tbl [256];

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = gf_double(a);
         b = b >> 1;
      end
      return p;
   endfunction

   initial begin
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h01;
         for (int e = 0; e < 254; e++) inv = gf_mul(inv, x[7:0]);
         if (x == 0) inv = 8'h00;
         sbox_tbl[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                     ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      end
   end

   // Full encryption with an on-the-fly key schedule; bytes indexed 0..15, 0 = MSB.
   function automatic aes_half_pair_type encrypt_block(input aes_half_pair_type pt);
      logic [7:0] st [16];
      logic [7:0] rk [16];
      logic [7:0] tmp [16];
      logic [7:0] rcon, k0, k1, k2, k3, a0, a1, a2, a3, all;
      aes_half_pair_type ct;
      rcon = 8'h01;
      for (int i = 0; i < 8; i++) begin
         st[i]     = pt.high[63 - 8 * i -: 8];
         st[8 + i] = pt.low[63 - 8 * i -: 8];
         rk[i]     = model_key_high[63 - 8 * i -: 8];
         rk[8 + i] = model_key_low[63 - 8 * i -: 8];
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         // key schedule: RotWord, SubWord, Rcon, then XOR chain
         k0 = rcon ^ sbox_tbl[rk[13]];
         k1 = sbox_tbl[rk[14]];
         k2 = sbox_tbl[rk[15]];
         k3 = sbox_tbl[rk[12]];
         rk[0] ^= k0; rk[1] ^= k1; rk[2] ^= k2; rk[3] ^= k3;
         for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
         rcon = gf_double(rcon);
         // SubBytes + ShiftRows: byte 4*c+r is row r, column c
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               tmp[4 * c + r] = sbox_tbl[st[4 * ((c + r) % 4) + r]];
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = tmp[4 * c]; a1 = tmp[4 * c + 1];
               a2 = tmp[4 * c + 2]; a3 = tmp[4 * c + 3];
               all = a0 ^ a1 ^ a2 ^ a3;
               tmp[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
               tmp[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
               tmp[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
               tmp[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
      end
      for (int i = 0; i < 8; i++) begin
         ct.high[63 - 8 * i -: 8] = st[i];
         ct.low[63 - 8 * i -: 8]  = st[8 + i];
      end
      return ct;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %016h, want %016h", what, got, want);
      error_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Driver: presents queued plaintext blocks with random gaps.
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.data_high <= '0;
         req_if.data_low  <= '0;
         send_gap         <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            cipher_q.push_back(encrypt_block('{req_if.data_high, req_if.data_low}));
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap     <= send_gap - 1;
               req_if.valid <= 1'b0;
            end else if (plain_q.size() > 0 && !hold_sender) begin
               req_if.valid     <= 1'b1;
               req_if.data_high <= plain_q[0].high;
               req_if.data_low  <= plain_q[0].low;
               void'(plain_q.pop_front());
               send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure on rsp, checks each transfer in order.
   int recv_gap;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_gap     <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (cipher_q.size() == 0) begin
               report_mismatch("unexpected ciphertext_high", rsp_if.data_high, 64'h0);
            end else begin
               if (rsp_if.data_high !== cipher_q[0].high)
                  report_mismatch("ciphertext_high", rsp_if.data_high, cipher_q[0].high);
               if (rsp_if.data_low !== cipher_q[0].low)
                  report_mismatch("ciphertext_low", rsp_if.data_low, cipher_q[0].low);
               void'(cipher_q.pop_front());
            end
         end
         if (recv_gap > 0) begin
            recv_gap     <= recv_gap - 1;
            rsp_if.ready <= 1'b0;
         end else if (rsp_if.valid && rsp_if.ready || !rsp_if.ready) begin
            rsp_if.ready <= 1'b1;
            if (rsp_if.valid && rsp_if.ready)
               recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         end
      end
   end

   // Watchdog: cycles without any transfer on either stream or a csr write.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || csr_if.valid)
         idle_cycles <= 0;
      else if (!(stim_done && cipher_q.size() == 0 && plain_q.size() == 0))
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WatchdogLimit) begin
         $display("aes128_block_encrypt_tb: done, errors");
         $finish;
      end
   end

   // Key register write; only called with the pipe drained.
   task automatic write_key(input logic [0:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == CsrKeyHigh) model_key_high = value;
      else model_key_low = value;
   endtask

   task automatic drain_pipe();
      while (plain_q.size() > 0 || req_if.valid || cipher_q.size() > 0)
         @(posedge clock);
      repeat (PipeLatency + 2) @(posedge clock);
   endtask

   task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo);
      plain_q.push_back('{hi, lo});
   endtask

   initial begin
      logic [63:0] hi, lo;
      error_count    = 0;
      stim_done      = 1'b0;
      hold_sender    = 1'b0;
      model_key_high = '0;
      model_key_low  = '0;
      reset          = 1'b1;
      csr_if.valid   = 1'b0;
      csr_if.index   = CsrKeyHigh;
      csr_if.data    = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // all-zero key after reset, field extremes
      queue_block('0, '0);
      queue_block('1, '1);
      queue_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
      queue_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      drain_pipe();

      // FIPS-197 appendix C.1 key, then all-ones key
      write_key(CsrKeyHigh, 64'h0001_0203_0405_0607);
      write_key(CsrKeyLow,  64'h0809_0a0b_0c0d_0e0f);
      queue_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      queue_block('0, '1);
      queue_block('1, '0);
      for (int i = 0; i < 6; i++) queue_block(rand64(), rand64());
      drain_pipe();
      write_key(CsrKeyHigh, '1);
      write_key(CsrKeyLow,  '1);
      queue_block('0, '0);
      queue_block('1, '1);
      for (int i = 0; i < 6; i++) queue_block(rand64(), rand64());
      drain_pipe();

      // random phases, new random key each phase (key_high zero in phase 4)
      for (int phase = 0; phase < 9; phase++) begin
         write_key(CsrKeyHigh, (phase == 4) ? 64'h0 : rand64());
         write_key(CsrKeyLow,  rand64());
         for (int i = 0; i < RandomBlocks / 9; i++) begin
            hi = rand64();
            lo = rand64();
            case ($urandom_range(0, 15))
               0: hi = '0;
               1: lo = '1;
               default: ;
            endcase
            queue_block(hi, lo);
         end
         if (phase == 2) begin
            // sender holds off mid-phase until the pipe has emptied
            while (plain_q.size() > RandomBlocks / 18) @(posedge clock);
            hold_sender = 1'b1;
            while (req_if.valid || cipher_q.size() > 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain_pipe();
      end

      stim_done = 1'b1;
      if (error_count == 0)
         $display("aes128_block_encrypt_tb: done, clean");
      else
         $display("aes128_block_encrypt_tb: done, errors");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/aes_pkg.sv
rtl/aes_if.sv
rtl/aes_round_stage.sv
rtl/aes128_block_encrypt.sv
verif/aes128_block_encrypt_tb_if.sv
verif/aes128_block_encrypt_tb.sv
